>>> design/dsoo_pkg.sv
// Package for the dual sawtooth octave oscillator.
// Holds field widths, register indexes, reset values, the control sequencer state type
// and the status struct passed from the frequency control to the ramp core. No dependencies.
package dsoo_pkg;

	localparam int CV_BITS      = 10;
	localparam int RAMP_BITS    = 8;
	localparam int FREQ_BITS    = 10;
	localparam int TB_BITS      = 24;
	localparam int CFG_IDX_BITS = 3;

	// Product of a sample and a frequency span, and the divider operand widths.
	localparam int PROD_BITS = CV_BITS + FREQ_BITS;
	localparam int DIV_DW    = PROD_BITS;
	localparam int DIV_VW    = FREQ_BITS;

	// Full-scale converter reading, the denominator of the voltage mapping.
	localparam logic [DIV_VW-1:0] CV_FULL_SCALE = DIV_VW'((1 << CV_BITS) - 1);

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] CFG_TIMEBASE  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FREQ_LO   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_FREQ_HI   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_TOP  = 3'd4;

	// Register reset values.
	localparam logic [TB_BITS-1:0]   TIMEBASE_RST  = 24'd10000000;
	localparam logic [FREQ_BITS-1:0] FREQ_LO_RST   = 10'd20;
	localparam logic [FREQ_BITS-1:0] FREQ_HI_RST   = 10'd500;
	localparam logic [CV_BITS-1:0]   THRESHOLD_RST = 10'd5;
	localparam logic [RAMP_BITS-1:0] RAMP_TOP_RST  = 8'd255;

	// Divider periods in force after reset.
	localparam int MAIN_PERIOD_RST = 78;
	localparam int SUB_PERIOD_RST  = 156;

	// Command codes of an input word.
	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_CV   = 1'b1;

	typedef enum logic [2:0] {
		CTL_IDLE,
		CTL_MAP,
		CTL_CLAMP,
		CTL_MAIN,
		CTL_SUB
	} ctl_state_t;

	// Frequency change status seen by the ramp core.
	typedef struct packed {
		logic change_pending;
		logic pending_nz;
	} pend_t;

endpackage

>>> design/dsoo_serial_div.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Shared by the voltage mapping and both period computations. Uses no package.
module dsoo_serial_div #(
	parameter int DW = 20,
	parameter int VW = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;

	logic          running;
	logic [VW:0]   trial;
	logic [VW:0]   diff;
	logic          ge;

	assign running = (cnt_q != '0);
	assign trial   = {rem_q, quo_q[DW-1]};
	assign ge      = (trial >= {1'b0, dvs_q});
	assign diff    = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= running && (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(DW);
			end else if (running) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (running) begin
			rem_q <= ge ? diff[VW-1:0] : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> design/dsoo_freq_ctrl.sv
// Frequency control: threshold test on voltage samples, linear mapping, clamping and
// precomputation of both periods through the shared serial divider. Uses dsoo_pkg.
module dsoo_freq_ctrl
	import dsoo_pkg::*;
#(
	parameter int PERIOD_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cv_take,
	input  logic [CV_BITS-1:0]     cv_sample,
	input  logic                   recompute,
	input  logic                   apply,
	input  logic [TB_BITS-1:0]     timebase_hz,
	input  logic [FREQ_BITS-1:0]   freq_lo,
	input  logic [FREQ_BITS-1:0]   freq_hi,
	input  logic [CV_BITS-1:0]     cv_thresh,
	output logic                   idle,
	output pend_t                  pend,
	output logic [PERIOD_BITS-1:0] main_next,
	output logic [PERIOD_BITS-1:0] sub_next
);

	localparam int WW = (PERIOD_BITS > DIV_DW) ? PERIOD_BITS : DIV_DW;

	ctl_state_t state_q, state_n;

	logic [CV_BITS-1:0]     last_cv_q;
	logic [FREQ_BITS-1:0]   pending_q;
	logic                   change_q;
	logic [FREQ_BITS-1:0]   f_q;
	logic [PERIOD_BITS-1:0] main_next_q;
	logic [PERIOD_BITS-1:0] sub_next_q;

	logic [CV_BITS-1:0]   cv_diff;
	logic                 cv_start;
	logic                 span_neg;
	logic [FREQ_BITS-1:0] span_mag;
	logic [PROD_BITS-1:0] product;
	logic [FREQ_BITS-1:0] mapped;
	logic [FREQ_BITS-1:0] f_clamp;
	logic [FREQ_BITS-1:0] f_low;

	logic                 div_start;
	logic [DIV_DW-1:0]    div_dividend;
	logic [DIV_VW-1:0]    div_divisor;
	logic                 div_done;
	logic [DIV_DW-1:0]    div_quot;

	function automatic logic [PERIOD_BITS-1:0] sat_period(input logic [DIV_DW-1:0] q);
		logic [WW-1:0] qw;
		logic [WW-1:0] pmax;
		qw   = WW'(q);
		pmax = WW'({PERIOD_BITS{1'b1}});
		return (qw > pmax) ? {PERIOD_BITS{1'b1}} : qw[PERIOD_BITS-1:0];
	endfunction

	assign cv_diff  = (cv_sample > last_cv_q) ? (cv_sample - last_cv_q)
	                                          : (last_cv_q - cv_sample);
	assign cv_start = cv_take && (cv_diff > cv_thresh);

	// Sign and magnitude of the span; the mapping truncates toward zero.
	assign span_neg = (freq_hi < freq_lo);
	assign span_mag = span_neg ? (freq_lo - freq_hi) : (freq_hi - freq_lo);
	assign product  = PROD_BITS'(cv_sample) * PROD_BITS'(span_mag);

	assign mapped = span_neg ? (freq_lo - div_quot[FREQ_BITS-1:0])
	                         : (freq_lo + div_quot[FREQ_BITS-1:0]);

	assign f_low   = (pending_q < freq_lo) ? freq_lo : pending_q;
	assign f_clamp = (f_low > freq_hi) ? freq_hi : f_low;

	dsoo_serial_div #(
		.DW(DIV_DW),
		.VW(DIV_VW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	// Next state.
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			CTL_IDLE: begin
				if (cv_start) begin
					state_n = CTL_MAP;
				end else if (recompute) begin
					state_n = CTL_CLAMP;
				end
			end
			CTL_MAP: begin
				if (div_done) begin
					state_n = CTL_CLAMP;
				end
			end
			CTL_CLAMP: begin
				state_n = CTL_MAIN;
			end
			CTL_MAIN: begin
				if (div_done) begin
					state_n = CTL_SUB;
				end
			end
			CTL_SUB: begin
				if (div_done) begin
					state_n = CTL_IDLE;
				end
			end
			default: begin
				state_n = CTL_IDLE;
			end
		endcase
	end

	// Divider launch and status.
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		idle         = 1'b0;
		unique case (state_q)
			CTL_IDLE: begin
				idle         = 1'b1;
				div_start    = cv_start;
				div_dividend = product;
				div_divisor  = CV_FULL_SCALE;
			end
			CTL_CLAMP: begin
				div_start    = 1'b1;
				div_dividend = DIV_DW'(timebase_hz[TB_BITS-1:8]);
				div_divisor  = f_clamp;
			end
			CTL_MAIN: begin
				div_start    = div_done;
				div_dividend = DIV_DW'(timebase_hz[TB_BITS-1:8]);
				div_divisor  = {1'b0, f_q[FREQ_BITS-1:1]};
			end
			CTL_MAP, CTL_SUB: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= CTL_IDLE;
			last_cv_q <= '0;
			pending_q <= '0;
			change_q  <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cv_start) begin
				last_cv_q <= cv_sample;
				change_q  <= 1'b1;
			end
			if (state_q == CTL_MAP && div_done) begin
				pending_q <= mapped;
			end
			if (apply) begin
				pending_q <= '0;
				change_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CTL_CLAMP) begin
			f_q <= f_clamp;
		end
		if (state_q == CTL_MAIN && div_done) begin
			main_next_q <= sat_period(div_quot);
		end
		if (state_q == CTL_SUB && div_done) begin
			sub_next_q <= sat_period(div_quot);
		end
	end

	assign pend.change_pending = change_q;
	assign pend.pending_nz     = (pending_q != '0);
	assign main_next           = main_next_q;
	assign sub_next            = sub_next_q;

endmodule

>>> design/dsoo_ramp_core.sv
// Ramp core: the two tick dividers, the two ramps and the mix of both.
// Applies a precomputed period pair at a main step from zero. Uses dsoo_pkg.
module dsoo_ramp_core
	import dsoo_pkg::*;
#(
	parameter int PERIOD_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   tick,
	input  logic [RAMP_BITS-1:0]   ramp_top,
	input  pend_t                  pend,
	input  logic [PERIOD_BITS-1:0] main_next,
	input  logic [PERIOD_BITS-1:0] sub_next,
	output logic                   apply,
	output logic                   res_valid,
	output logic [RAMP_BITS-1:0]   res_dac,
	output logic [RAMP_BITS-1:0]   res_ramp
);

	logic [PERIOD_BITS-1:0] main_cnt_q, sub_cnt_q;
	logic [PERIOD_BITS-1:0] main_per_q, sub_per_q;
	logic [RAMP_BITS-1:0]   main_ramp_q, sub_ramp_q;

	logic [PERIOD_BITS-1:0] main_cnt_inc, sub_cnt_inc;
	logic                   main_fire, sub_fire;
	logic [RAMP_BITS-1:0]   main_ramp_n, sub_ramp_n;
	logic [RAMP_BITS:0]     mix_sum;

	function automatic logic [RAMP_BITS-1:0] ramp_step(input logic [RAMP_BITS-1:0] v,
	                                                   input logic [RAMP_BITS-1:0] top);
		logic [RAMP_BITS:0] n;
		n = {1'b0, v} + (RAMP_BITS+1)'(1);
		return (n > {1'b0, top}) ? '0 : n[RAMP_BITS-1:0];
	endfunction

	assign sub_cnt_inc  = sub_cnt_q + PERIOD_BITS'(1);
	assign main_cnt_inc = main_cnt_q + PERIOD_BITS'(1);
	assign sub_fire     = (sub_cnt_inc >= sub_per_q);
	assign main_fire    = (main_cnt_inc >= main_per_q);

	assign sub_ramp_n  = sub_fire ? ramp_step(sub_ramp_q, ramp_top) : sub_ramp_q;
	assign main_ramp_n = ramp_step(main_ramp_q, ramp_top);

	assign apply = tick && main_fire && (main_ramp_q == '0)
	               && pend.change_pending && pend.pending_nz;

	assign mix_sum   = {1'b0, main_ramp_n} + {1'b0, sub_ramp_n};
	assign res_valid = tick && main_fire;
	assign res_dac   = mix_sum[RAMP_BITS:1];
	assign res_ramp  = main_ramp_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_cnt_q  <= '0;
			sub_cnt_q   <= '0;
			main_per_q  <= PERIOD_BITS'(MAIN_PERIOD_RST);
			sub_per_q   <= PERIOD_BITS'(SUB_PERIOD_RST);
			main_ramp_q <= '0;
			sub_ramp_q  <= '0;
		end else if (tick) begin
			sub_cnt_q  <= sub_fire ? '0 : sub_cnt_inc;
			sub_ramp_q <= sub_ramp_n;
			main_cnt_q <= main_fire ? '0 : main_cnt_inc;
			if (main_fire) begin
				main_ramp_q <= main_ramp_n;
			end
			if (apply) begin
				main_per_q <= main_next;
				sub_per_q  <= sub_next;
			end
		end
	end

endmodule

>>> design/dsoo_out_queue.sv
// Two-entry result queue between the ramp core and the output channel.
// Keeps a waiting word apart from the next tick. Uses dsoo_pkg.
module dsoo_out_queue
	import dsoo_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic [RAMP_BITS-1:0] push_dac,
	input  logic [RAMP_BITS-1:0] push_ramp,
	input  logic                 pop_stall,
	output logic                 full,
	output logic                 head_valid,
	output logic [RAMP_BITS-1:0] head_dac,
	output logic [RAMP_BITS-1:0] head_ramp
);

	logic [RAMP_BITS-1:0] dac_q  [2];
	logic [RAMP_BITS-1:0] ramp_q [2];
	logic                 wr_q, rd_q;
	logic [1:0]           cnt_q;
	logic                 pop;

	assign head_valid = (cnt_q != 2'd0);
	assign full       = (cnt_q == 2'd2);
	assign pop        = head_valid && !pop_stall;
	assign head_dac   = dac_q[rd_q];
	assign head_ramp  = ramp_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			dac_q[wr_q]  <= push_dac;
			ramp_q[wr_q] <= push_ramp;
		end
	end

endmodule

>>> design/dual_sawtooth_octave_oscillator.sv
// Top level of the dual sawtooth octave oscillator.
// Holds the configuration registers and joins frequency control, ramp core and
// result queue. Uses dsoo_pkg and the dsoo_* modules.
//
// The item channel (item_valid, item_stall, command, cv_sample) carries one word per
// timebase tick (command 0) or per control-voltage sample (command 1). A tick word that
// makes the main divider fire yields one result word on the result channel (result_valid,
// result_stall, dac_value, main_ramp) through the result queue; other words yield
// nothing. While item_stall is low, ticks are taken back to back, one per cycle.
// A sample that moves more than the threshold away from the last accepted one starts a
// precomputation on the shared bit-serial divider: three 20-step divisions (voltage
// mapping, main period, sub period) with a clamp state after the first one, during
// which item_stall stays high. A write to the timebase, lowest or highest frequency
// register reruns the clamp and both period divisions, so that a pending frequency
// meets the current settings. Configuration words (cfg_valid, cfg_ready, cfg_index,
// cfg_data) are taken while the divider is idle; unknown indexes are dropped.
// Results pass through a two-entry queue, so a stalled receiver holds its word while ticks
// keep coming; beside the divider, item_stall rises only when the queue is full.
// Reset loads the register defaults, clears both ramps and counts and sets the main and
// sub periods to 78 and 156 ticks.
module dual_sawtooth_octave_oscillator
	import dsoo_pkg::*;
#(
	parameter int PERIOD_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic                    command,
	input  logic [CV_BITS-1:0]      cv_sample,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic [RAMP_BITS-1:0]    dac_value,
	output logic [RAMP_BITS-1:0]    main_ramp,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [TB_BITS-1:0]      cfg_data
);

	logic [TB_BITS-1:0]   timebase_q;
	logic [FREQ_BITS-1:0] freq_lo_q;
	logic [FREQ_BITS-1:0] freq_hi_q;
	logic [CV_BITS-1:0]   threshold_q;
	logic [RAMP_BITS-1:0] ramp_top_q;

	logic                   ctl_idle;
	logic                   q_full;
	logic                   item_take;
	logic                   cfg_take;
	logic                   recompute;
	logic                   apply;
	pend_t                  pend;
	logic [PERIOD_BITS-1:0] main_next;
	logic [PERIOD_BITS-1:0] sub_next;
	logic                   res_valid;
	logic [RAMP_BITS-1:0]   res_dac;
	logic [RAMP_BITS-1:0]   res_ramp;

	// Items wait while the divider is busy or the result queue has no room.
	assign item_stall = !ctl_idle || q_full;
	assign item_take  = item_valid && !item_stall;
	assign cfg_ready  = ctl_idle;
	assign cfg_take   = cfg_valid && cfg_ready;

	// Registers that feed the period divisions force a recomputation.
	assign recompute = cfg_take && ((cfg_index == CFG_TIMEBASE)
	                                || (cfg_index == CFG_FREQ_LO)
	                                || (cfg_index == CFG_FREQ_HI));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timebase_q  <= TIMEBASE_RST;
			freq_lo_q   <= FREQ_LO_RST;
			freq_hi_q   <= FREQ_HI_RST;
			threshold_q <= THRESHOLD_RST;
			ramp_top_q  <= RAMP_TOP_RST;
		end else if (cfg_take) begin
			unique case (cfg_index)
				CFG_TIMEBASE:  timebase_q  <= cfg_data;
				CFG_FREQ_LO:   freq_lo_q   <= cfg_data[FREQ_BITS-1:0];
				CFG_FREQ_HI:   freq_hi_q   <= cfg_data[FREQ_BITS-1:0];
				CFG_THRESHOLD: threshold_q <= cfg_data[CV_BITS-1:0];
				CFG_RAMP_TOP:  ramp_top_q  <= cfg_data[RAMP_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	dsoo_freq_ctrl #(
		.PERIOD_BITS(PERIOD_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cv_take      (item_take && (command == CMD_CV)),
		.cv_sample    (cv_sample),
		.recompute    (recompute),
		.apply        (apply),
		.timebase_hz  (timebase_q),
		.freq_lo      (freq_lo_q),
		.freq_hi      (freq_hi_q),
		.cv_thresh    (threshold_q),
		.idle         (ctl_idle),
		.pend         (pend),
		.main_next    (main_next),
		.sub_next     (sub_next)
	);

	dsoo_ramp_core #(
		.PERIOD_BITS(PERIOD_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (item_take && (command == CMD_TICK)),
		.ramp_top  (ramp_top_q),
		.pend      (pend),
		.main_next (main_next),
		.sub_next  (sub_next),
		.apply     (apply),
		.res_valid (res_valid),
		.res_dac   (res_dac),
		.res_ramp  (res_ramp)
	);

	dsoo_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_dac   (res_dac),
		.push_ramp  (res_ramp),
		.pop_stall  (result_stall),
		.full       (q_full),
		.head_valid (result_valid),
		.head_dac   (dac_value),
		.head_ramp  (main_ramp)
	);

endmodule

>>> design/dsoo_checker.sv
// Port-level checker for the dual sawtooth octave oscillator, bound to the top level.
// Uses dsoo_pkg and watches only the top level's ports.
module dsoo_checker
	import dsoo_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    item_stall,
	input logic                    result_valid,
	input logic                    result_stall,
	input logic [RAMP_BITS-1:0]    dac_value,
	input logic [RAMP_BITS-1:0]    main_ramp,
	input logic                    cfg_ready
);

	logic [RAMP_BITS-1:0] last_ramp_q;
	logic                 seen_q;
	logic                 res_take;

	assign res_take = result_valid && !result_stall;

	// Last delivered main ramp value, to check the ramp sequence.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (res_take) begin
			seen_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			last_ramp_q <= main_ramp;
		end
	end

	// A stalled result word holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=>
			(result_valid && $stable(dac_value) && $stable(main_ramp)))
		else $error("result word changed while stalled");

	// Each main ramp value delivered follows the last one by one step or a wrap.
	a_ramp_step: assert property (@(posedge clk) disable iff (!arst_n)
		(res_take && seen_q) |->
			((main_ramp == RAMP_BITS'(last_ramp_q + RAMP_BITS'(1))) || (main_ramp == '0)))
		else $error("main ramp skipped a step");

	// While the divider runs, no item is taken.
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_ready |-> item_stall)
		else $error("item taken during period computation");

	// With the divider idle, items wait only behind a waiting result.
	a_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_ready && item_stall) |-> result_valid)
		else $error("item stalled with no work outstanding");

endmodule

bind dual_sawtooth_octave_oscillator dsoo_checker u_dsoo_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.dac_value    (dac_value),
	.main_ramp    (main_ramp),
	.cfg_ready    (cfg_ready)
);

>>> sim/dual_sawtooth_octave_oscillator_test.sv
// Self-checking testbench for the dual sawtooth octave oscillator.
// Drives ticks, voltage samples and register writes, and checks every result word
// against a predictor kept here or a typed-in result. Depends on dsoo_pkg and the oscillator RTL.
`timescale 1ns / 100ps

module dual_sawtooth_octave_oscillator_test;
	import dsoo_pkg::*;

	localparam int PERIOD_BITS   = 16;
	localparam int SETTLE_CYCLES = 120;
	localparam int TIMEOUT_NS    = 2_000_000;
	localparam int PHASES        = 8;
	localparam int PHASE_WORDS   = 198;
	localparam int IDLE_PCT      = 11;

	// An index past the last register, which the block must ignore.
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNMAPPED = 3'd7;

	typedef struct packed {
		logic [RAMP_BITS-1:0] dac;
		logic [RAMP_BITS-1:0] ramp;
	} osc_word_t;

	// One line of the directed script: a run of ticks, one sample, or one register write.
	typedef enum logic [1:0] {ROW_TICK, ROW_CV, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [CFG_IDX_BITS-1:0] idx;
		logic [TB_BITS-1:0]      val;
		logic [7:0]              reps;
		logic                    known;
		logic [RAMP_BITS-1:0]    k_dac;
		logic [RAMP_BITS-1:0]    k_ramp;
	} script_row_t;

	// The typed-in results are for the last word of their row. Right after reset the
	// periods are 78 and 156 ticks, so the first main step lands on tick 78 with the
	// sub ramp still at zero, and the second on tick 156 together with the first sub
	// step. Lowering the ramp top below the main ramp makes the next step wrap to zero.
	localparam script_row_t SCRIPT [25] = '{
		'{ROW_TICK, '0,            24'd0,        8'd77, 1'b0, 8'd0, 8'd0},
		'{ROW_TICK, '0,            24'd0,        8'd1,  1'b1, 8'd0, 8'd1},
		'{ROW_TICK, '0,            24'd0,        8'd78, 1'b1, 8'd1, 8'd2},
		'{ROW_CV,   '0,            24'd0,        8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_CV,   '0,            24'd5,        8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_CV,   '0,            24'd6,        8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_CFG,  CFG_RAMP_TOP,  24'd1,        8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_TICK, '0,            24'd0,        8'd78, 1'b1, 8'd0, 8'd0},
		'{ROW_CFG,  CFG_FREQ_HI,   24'd1000,     8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_CFG,  CFG_TIMEBASE,  24'd1,        8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_TICK, '0,            24'd0,        8'd78, 1'b0, 8'd0, 8'd0},
		'{ROW_TICK, '0,            24'd0,        8'd4,  1'b0, 8'd0, 8'd0},
		'{ROW_CV,   '0,            24'd1023,     8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_CFG,  CFG_FREQ_LO,   24'd1000,     8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_CFG,  CFG_FREQ_HI,   24'd2,        8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_CFG,  CFG_TIMEBASE,  24'd2560,     8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_TICK, '0,            24'd0,        8'd12, 1'b0, 8'd0, 8'd0},
		'{ROW_CV,   '0,            24'd512,      8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_CFG,  CFG_THRESHOLD, 24'd1023,     8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_CV,   '0,            24'd0,        8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_CFG,  CFG_THRESHOLD, 24'd0,        8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_CV,   '0,            24'd513,      8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_CFG,  CFG_UNMAPPED,  24'hFFFFFF,   8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_CFG,  CFG_RAMP_TOP,  24'd255,      8'd1,  1'b0, 8'd0, 8'd0},
		'{ROW_TICK, '0,            24'd0,        8'd30, 1'b0, 8'd0, 8'd0}
	};

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    item_valid   = 1'b0;
	logic                    item_stall;
	logic                    command      = CMD_TICK;
	logic [CV_BITS-1:0]      cv_sample    = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic [RAMP_BITS-1:0]    dac_value;
	logic [RAMP_BITS-1:0]    main_ramp;
	logic                    cfg_valid    = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
	logic [TB_BITS-1:0]      cfg_data     = '0;

	// Set during one random phase to give a long run with no gaps on either side.
	bit quiet = 1'b0;

	osc_word_t expected_words[$];
	int        mismatch_count = 0;

	// Predictor copy of the registers.
	logic [TB_BITS-1:0]   reg_timebase;
	logic [FREQ_BITS-1:0] reg_freq_lo;
	logic [FREQ_BITS-1:0] reg_freq_hi;
	logic [CV_BITS-1:0]   reg_threshold;
	logic [RAMP_BITS-1:0] reg_ramp_top;

	// Predictor copy of the oscillator state.
	logic [PERIOD_BITS-1:0] main_count, sub_count, main_per, sub_per;
	logic [RAMP_BITS-1:0]   main_saw, sub_saw;
	logic [FREQ_BITS-1:0]   freq_pending;
	logic [CV_BITS-1:0]     cv_last;
	logic                   freq_change;

	dual_sawtooth_octave_oscillator #(
		.PERIOD_BITS(PERIOD_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.command(command),
		.cv_sample(cv_sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.dac_value(dac_value),
		.main_ramp(main_ramp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// The receiver stalls at random, except during the quiet phase.
	always @(posedge clk) begin
		result_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
	end

	// Ticks per step for frequency f: the timebase over 256 f, saturated to all ones.
	// A zero frequency has no finite period and also gives all ones.
	function automatic logic [PERIOD_BITS-1:0] period_of(input logic [FREQ_BITS-1:0] f);
		longint unsigned num, den, q;
		if (f == 0)
			return '1;
		num = reg_timebase;
		den = f;
		q = num / (den * 256);
		if (q > ((64'd1 << PERIOD_BITS) - 1))
			return '1;
		return q[PERIOD_BITS-1:0];
	endfunction

	function automatic logic [RAMP_BITS-1:0] ramp_after(input logic [RAMP_BITS-1:0] v);
		logic [RAMP_BITS:0] n;
		n = {1'b0, v} + 1'b1;
		if (n > {1'b0, reg_ramp_top})
			n = '0;
		return n[RAMP_BITS-1:0];
	endfunction

	task automatic reset_oscillator_model();
		reg_timebase  = TIMEBASE_RST;
		reg_freq_lo   = FREQ_LO_RST;
		reg_freq_hi   = FREQ_HI_RST;
		reg_threshold = THRESHOLD_RST;
		reg_ramp_top  = RAMP_TOP_RST;
		main_count    = '0;
		sub_count     = '0;
		main_per      = PERIOD_BITS'(MAIN_PERIOD_RST);
		sub_per       = PERIOD_BITS'(SUB_PERIOD_RST);
		main_saw      = '0;
		sub_saw       = '0;
		cv_last       = '0;
		freq_pending  = '0;
		freq_change   = 1'b0;
	endtask

	task automatic store_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [TB_BITS-1:0] data);
		case (idx)
			CFG_TIMEBASE:  reg_timebase  = data;
			CFG_FREQ_LO:   reg_freq_lo   = data[FREQ_BITS-1:0];
			CFG_FREQ_HI:   reg_freq_hi   = data[FREQ_BITS-1:0];
			CFG_THRESHOLD: reg_threshold = data[CV_BITS-1:0];
			CFG_RAMP_TOP:  reg_ramp_top  = data[RAMP_BITS-1:0];
			default: ;
		endcase
	endtask

	// Advances the oscillator by one accepted word and says whether it makes a result.
	task automatic advance_oscillator(input logic cmd, input logic [CV_BITS-1:0] cv,
			output bit has_word, output osc_word_t word);
		logic [CV_BITS-1:0]   diff;
		logic [FREQ_BITS-1:0] f;
		longint               lo, hi, cvl, mapped;
		has_word = 1'b0;
		word = '0;
		if (cmd == CMD_CV) begin
			diff = (cv > cv_last) ? cv - cv_last : cv_last - cv;
			if (diff > reg_threshold) begin
				// Linear map onto [min, max]; with min above max it runs downward and
				// the division truncates toward zero.
				lo = reg_freq_lo;
				hi = reg_freq_hi;
				cvl = cv;
				mapped = (cvl * (hi - lo)) / 1023 + lo;
				cv_last = cv;
				freq_pending = mapped[FREQ_BITS-1:0];
				freq_change = 1'b1;
			end
			return;
		end
		// The sub divider goes first, so a main step on the same tick mixes the new sub ramp.
		sub_count = sub_count + 1'b1;
		if (sub_count >= sub_per) begin
			sub_count = '0;
			sub_saw = ramp_after(sub_saw);
		end
		main_count = main_count + 1'b1;
		if (main_count < main_per)
			return;
		main_count = '0;
		// A new frequency only takes hold at the start of a main ramp cycle.
		if (main_saw == 0 && freq_change && freq_pending != 0) begin
			f = freq_pending;
			if (f < reg_freq_lo)
				f = reg_freq_lo;
			if (f > reg_freq_hi)
				f = reg_freq_hi;
			main_per = period_of(f);
			sub_per = period_of(f >> 1);
			freq_pending = '0;
			freq_change = 1'b0;
		end
		main_saw = ramp_after(main_saw);
		word.dac = RAMP_BITS'(({1'b0, main_saw} + {1'b0, sub_saw}) >> 1);
		word.ramp = main_saw;
		has_word = 1'b1;
	endtask

	task automatic report_mismatch(input string what, input osc_word_t want, input osc_word_t got);
		if (mismatch_count < 10)
			$display("mismatch (%s) at %0t: expected dac %0d ramp %0d, got dac %0d ramp %0d",
				what, $realtime, want.dac, want.ramp, got.dac, got.ramp);
		mismatch_count++;
	endtask

	// Every accepted result word is checked against the oldest expectation.
	always @(posedge clk) begin : watch_results
		osc_word_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_words.size() == 0) begin
				report_mismatch("no word expected", '0, {dac_value, main_ramp});
			end else begin
				want = expected_words.pop_front();
				if (want.dac !== dac_value || want.ramp !== main_ramp)
					report_mismatch("wrong word", want, {dac_value, main_ramp});
			end
		end
	end

	// Offers one word on the item channel, with random gaps ahead of it, and holds it
	// until it is taken. A typed-in result replaces the predicted one for that word.
	task automatic push_word(input logic cmd, input logic [CV_BITS-1:0] cv,
			input bit typed, input osc_word_t typed_word);
		bit        has_word;
		osc_word_t word;
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		command <= cmd;
		cv_sample <= cv;
		do @(posedge clk); while (item_stall);
		advance_oscillator(cmd, cv, has_word, word);
		if (typed)
			expected_words.push_back(typed_word);
		else if (has_word)
			expected_words.push_back(word);
	endtask

	// Waits until every expected word has come, then lets the block settle. A sample
	// or a register write may still keep the divider busy after the last result.
	task automatic drain_results();
		item_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes one register; the last write of a batch lowers the valid after it is taken.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [TB_BITS-1:0] data,
			input bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		store_reg(idx, data);
		if (last)
			cfg_valid <= 1'b0;
	endtask

	function automatic logic [FREQ_BITS-1:0] pick_freq();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 20)
			return 10'd2;
		if (r < 30)
			return 10'd1000;
		return FREQ_BITS'($urandom_range(2, 1000));
	endfunction

	// Samples mostly land either anywhere, right around the threshold from the last
	// accepted one, or at the ends of the converter range.
	function automatic logic [CV_BITS-1:0] pick_sample();
		int unsigned r;
		int          v;
		r = $urandom_range(99);
		if (r < 40)
			return CV_BITS'($urandom());
		if (r < 70) begin
			v = int'(reg_threshold) + $urandom_range(0, 2) - 1;
			v = $urandom_range(1) ? int'(cv_last) + v : int'(cv_last) - v;
			if (v < 0)
				v = 0;
			if (v > 1023)
				v = 1023;
			return CV_BITS'(v);
		end
		return (r < 85) ? '0 : '1;
	endfunction

	initial begin : run_stimulus
		script_row_t              row;
		logic [TB_BITS-1:0]       tb;
		logic [FREQ_BITS-1:0]     lo_f, hi_f;
		logic [CV_BITS-1:0]       thr;
		logic [RAMP_BITS-1:0]     top;
		int unsigned              r;

		reset_oscillator_model();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: reset values, threshold edges, extremes of every register and
		// the odd cases (zero period, ramp top under the ramp, minimum above maximum,
		// an index past the last register).
		for (int i = 0; i < $size(SCRIPT); i++) begin
			row = SCRIPT[i];
			if (row.kind == ROW_CFG) begin
				drain_results();
				write_reg(row.idx, row.val, 1'b1);
			end else begin
				for (int n = 0; n < row.reps; n++)
					push_word(row.kind == ROW_CV ? CMD_CV : CMD_TICK, row.val[CV_BITS-1:0],
						row.known && (n == row.reps - 1), {row.k_dac, row.k_ramp});
			end
		end

		// Random part: each phase picks new settings while the block is idle, then
		// plays mostly ticks with a sprinkling of samples. Past the first phase the timebase is kept
		// small against the frequency range so that periods stay short and results plenty.
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			case (phase)
				0: begin
					tb = '1;
					lo_f = 10'd1000;
					hi_f = 10'd1000;
					top = 8'd255;
				end
				1: begin
					tb = 24'd1;
					lo_f = 10'd2;
					hi_f = 10'd2;
					top = 8'd1;
				end
				default: begin
					lo_f = pick_freq();
					hi_f = pick_freq();
					tb = TB_BITS'($urandom_range(1,
						256 * 6 * ((lo_f < hi_f) ? int'(lo_f) : int'(hi_f))));
					r = $urandom_range(99);
					top = (r < 70) ? RAMP_BITS'($urandom_range(1, 8)) :
						(r < 80) ? 8'd255 : RAMP_BITS'($urandom_range(1, 255));
				end
			endcase
			r = $urandom_range(99);
			thr = (r < 15) ? '0 : (r < 25) ? '1 : CV_BITS'($urandom_range(0, 30));
			quiet = (phase == 4);

			write_reg(CFG_TIMEBASE, tb, 1'b0);
			write_reg(CFG_FREQ_LO, TB_BITS'(lo_f), 1'b0);
			write_reg(CFG_FREQ_HI, TB_BITS'(hi_f), 1'b0);
			write_reg(CFG_THRESHOLD, TB_BITS'(thr), 1'b0);
			if (phase % 2 == 1)
				write_reg(CFG_IDX_BITS'(CFG_RAMP_TOP + 1 + $urandom_range(0, 2)),
					TB_BITS'($urandom()), 1'b0);
			write_reg(CFG_RAMP_TOP, TB_BITS'(top), 1'b1);

			for (int n = 0; n < PHASE_WORDS; n++) begin
				if ($urandom_range(99) < 6)
					push_word(CMD_CV, pick_sample(), 1'b0, '0);
				else
					push_word(CMD_TICK, CV_BITS'($urandom()), 1'b0, '0);
			end
		end

		quiet = 1'b0;
		drain_results();
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#(TIMEOUT_NS);
		$display("== FAIL ==");
		$finish;
	end

endmodule
